// ----- rtl/assert_macros.svh -----
// assertion macros used by the histogram builder core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property checked on every rising edge outside reset
`define EWH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never hold outside reset
`define EWH_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- rtl/ewh_pkg.sv -----
// shared types and constants for the equi-width histogram builder
`timescale 1ns / 1ps
package ewh_pkg;
   localparam int DEF_MAX_SAMPLES = 1024;
   localparam int DEF_MAX_BINS    = 64;

   localparam int SAMPLE_W   = 32;
   localparam int BIN_W      = 6;
   localparam int TALLY_W    = 11;
   localparam int GRAND_W    = 17;
   localparam int CNT16_W    = 16;
   localparam int NB_W       = 7;
   localparam int QUOT_W     = 7;
   localparam int PROD_W     = SAMPLE_W + QUOT_W - 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int RSP_DATA_W = 136;
   localparam int RSP_USER_W = 2;

   localparam logic [SAMPLE_W-1:0] SIGN_BIT = {1'b1, {(SAMPLE_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] CSR_BIN_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NULLS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTINCT  = 2'd2;

   localparam logic [NB_W-1:0] BINS_RESET = 7'd16;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_result_type;
endpackage

// ----- rtl/ewh_divider.sv -----
// restoring divider, one quotient bit per cycle, for bin index computation
`timescale 1ns / 1ps
module ewh_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ewh_pkg::PROD_W-1:0]    dividend,
   input  logic [ewh_pkg::SAMPLE_W-1:0]  divisor,
   output ewh_pkg::div_result_type       result
);
   import ewh_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [2:0]        step_ff;
   logic [PROD_W-1:0] rem_ff;
   logic [PROD_W-1:0] dvs_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic              ge;

   assign ge = rem_ff >= dvs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= !start && busy_ff && (step_ff == 3'(QUOT_W-1));
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            rem_ff  <= dividend;
            dvs_ff  <= {divisor, {(QUOT_W-1){1'b0}}};
            quot_ff <= '0;
         end else if (busy_ff) begin
            if (ge) begin
               rem_ff <= rem_ff - dvs_ff;
            end
            quot_ff <= {quot_ff[QUOT_W-2:0], ge};
            dvs_ff  <= dvs_ff >> 1;
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'(QUOT_W-1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign result.done     = done_ff;
   assign result.quotient = quot_ff;
endmodule

// ----- rtl/equi_width_histogram_builder_core.sv -----
// Equi-width histogram builder. Samples (req_tdata, req_tuser = present) stream in one per
// cycle in S_LOAD and are written to an on-chip sample memory while min and max are tracked;
// the transaction with req_tlast closes the set. Binning then walks the memory one sample at a
// time: memory read, a 32x7 multiply, a restoring divider and a read-modify-write of the bin
// counter memory. When all samples are equal the binning pass is skipped; a set with no stored
// sample gives a single empty result. Otherwise results follow one bin at a time while the
// output is free; a new set can start loading once the last result is registered. No input is
// taken from the closing transaction until the last result has been registered.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module equi_width_histogram_builder_core #(
   parameter int MAX_SAMPLES = ewh_pkg::DEF_MAX_SAMPLES,
   parameter int MAX_BINS    = ewh_pkg::DEF_MAX_BINS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ewh_pkg::SAMPLE_W-1:0]      req_tdata,  // sample
   input  logic                              req_tuser,  // sample_present
   input  logic                              req_tlast,  // is_final
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // bin_number, bin_tally, range_low, range_high, grand_total, distinct_out, nulls_out, pad
   output logic [ewh_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [ewh_pkg::RSP_USER_W-1:0]    rsp_tuser,  // empty_set, overflowed
   output logic                              rsp_tlast,  // last_result
   input  logic                              csr_wr_en,
   input  logic [ewh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ewh_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import ewh_pkg::*;

   localparam int HW  = $clog2(MAX_SAMPLES + 1);
   localparam int AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int BNW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

   typedef enum logic [3:0] {
      S_LOAD, S_EMPTY, S_DECIDE, S_RD, S_MUL, S_DIV, S_DIV_WAIT,
      S_CNT_RD, S_CNT_WR, S_EMIT_RD, S_EMIT_LD
   } state_type;

   state_type state_ff;

   logic [SAMPLE_W-1:0] store_mem [MAX_SAMPLES];
   logic [TALLY_W-1:0]  cnt_mem [MAX_BINS];
   logic [MAX_BINS-1:0] cnt_valid_ff;

   logic [NB_W-1:0]     bins_cfg_ff;
   logic [CSR_DATA_W-1:0] nulls_cfg_ff;
   logic [CSR_DATA_W-1:0] distinct_cfg_ff;

   logic [HW-1:0]       held_ff;
   logic [HW-1:0]       idx_ff;
   logic [SAMPLE_W-1:0] min_ff;
   logic [SAMPLE_W-1:0] max_ff;
   logic                ovf_ff;
   logic [BIN_W-1:0]    bin_ff;
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic [TALLY_W-1:0]  cnt_q_ff;
   logic [PROD_W-1:0]   prod_ff;

   logic                rsp_valid_ff;
   logic [BIN_W-1:0]    out_bin_ff;
   logic [TALLY_W-1:0]  out_tally_ff;
   logic [SAMPLE_W-1:0] out_lo_ff;
   logic [SAMPLE_W-1:0] out_hi_ff;
   logic [GRAND_W-1:0]  out_grand_ff;
   logic [CNT16_W-1:0]  out_distinct_ff;
   logic [CNT16_W-1:0]  out_nulls_ff;
   logic                out_empty_ff;
   logic                out_ovf_ff;
   logic                out_last_ff;

   logic [SAMPLE_W-1:0] biased;
   logic                accept;
   logic                store_ok;
   logic [HW-1:0]       held_in;
   logic [NB_W-1:0]     nb_eff;
   logic                out_free;
   logic                out_load;
   logic                span_zero;
   logic [BNW-1:0]      bin_idx;
   logic [TALLY_W-1:0]  cnt_cur;
   logic [TALLY_W-1:0]  tally_in;
   logic [NB_W-1:0]     bin_clamp;
   logic [GRAND_W-1:0]  grand_in;
   div_result_type      div_res;

   assign biased    = req_tdata ^ SIGN_BIT;
   assign req_tready = (state_ff == S_LOAD);
   assign accept    = req_tvalid && req_tready;
   assign store_ok  = req_tuser && (held_ff < HW'(MAX_SAMPLES));
   assign held_in   = held_ff + HW'(store_ok);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign out_load  = out_free && ((state_ff == S_EMIT_LD) || (state_ff == S_EMPTY));
   assign span_zero = (max_ff == min_ff);
   assign bin_idx   = bin_ff[BNW-1:0];
   assign cnt_cur   = cnt_valid_ff[bin_idx] ? cnt_q_ff : '0;
   assign tally_in  = span_zero ? ((bin_ff == '0) ? TALLY_W'(held_ff) : '0) : cnt_cur;
   assign bin_clamp = (div_res.quotient >= nb_eff) ? (nb_eff - 7'd1) : div_res.quotient;
   assign grand_in  = GRAND_W'(18'(held_ff) + 18'(nulls_cfg_ff));

   always_comb begin
      if (bins_cfg_ff == '0) begin
         nb_eff = 7'd1;
      end else if (bins_cfg_ff > NB_W'(MAX_BINS)) begin
         nb_eff = NB_W'(MAX_BINS);
      end else begin
         nb_eff = bins_cfg_ff;
      end
   end

   ewh_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_DIV),
      .dividend (prod_ff),
      .divisor  (max_ff - min_ff),
      .result   (div_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bins_cfg_ff     <= BINS_RESET;
         nulls_cfg_ff    <= '0;
         distinct_cfg_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BIN_COUNT: bins_cfg_ff     <= csr_wr_data[NB_W-1:0];
            CSR_NULLS:     nulls_cfg_ff    <= csr_wr_data;
            CSR_DISTINCT:  distinct_cfg_ff <= csr_wr_data;
            default:       bins_cfg_ff     <= bins_cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store_ok) begin
         store_mem[held_ff[AW-1:0]] <= biased;
      end
      rd_data_ff <= store_mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      cnt_q_ff <= cnt_mem[bin_idx];
      if (state_ff == S_CNT_WR) begin
         cnt_mem[bin_idx] <= cnt_cur + 11'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         held_ff      <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         ovf_ff       <= 1'b0;
         cnt_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         bin_ff       <= '0;
      end else begin
         if (out_load) begin
            rsp_valid_ff    <= 1'b1;
            out_grand_ff    <= grand_in;
            out_distinct_ff <= distinct_cfg_ff;
            out_nulls_ff    <= nulls_cfg_ff;
            out_ovf_ff      <= ovf_ff;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_LOAD: begin
               if (accept) begin
                  if (store_ok) begin
                     held_ff <= held_in;
                     if (biased < min_ff) begin
                        min_ff <= biased;
                     end
                     if (biased > max_ff) begin
                        max_ff <= biased;
                     end
                  end
                  if (req_tuser && !store_ok) begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_tlast) begin
                     state_ff <= (held_in == '0) ? S_EMPTY : S_DECIDE;
                  end
               end
            end
            S_EMPTY: begin
               if (out_load) begin
                  out_bin_ff   <= '0;
                  out_tally_ff <= '0;
                  out_lo_ff    <= '0;
                  out_hi_ff    <= '0;
                  out_empty_ff <= 1'b1;
                  out_last_ff  <= 1'b1;
                  held_ff      <= '0;
                  min_ff       <= '1;
                  max_ff       <= '0;
                  ovf_ff       <= 1'b0;
                  cnt_valid_ff <= '0;
                  state_ff     <= S_LOAD;
               end
            end
            S_DECIDE: begin
               idx_ff   <= '0;
               bin_ff   <= '0;
               state_ff <= span_zero ? S_EMIT_RD : S_RD;
            end
            S_RD: state_ff <= S_MUL;
            S_MUL: begin
               prod_ff  <= PROD_W'(rd_data_ff - min_ff) * PROD_W'(nb_eff);
               state_ff <= S_DIV;
            end
            S_DIV: state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: begin
               if (div_res.done) begin
                  bin_ff   <= bin_clamp[BIN_W-1:0];
                  state_ff <= S_CNT_RD;
               end
            end
            S_CNT_RD: state_ff <= S_CNT_WR;
            S_CNT_WR: begin
               cnt_valid_ff[bin_idx] <= 1'b1;
               idx_ff <= idx_ff + HW'(1);
               if (idx_ff + HW'(1) == held_ff) begin
                  bin_ff   <= '0;
                  state_ff <= S_EMIT_RD;
               end else begin
                  state_ff <= S_RD;
               end
            end
            S_EMIT_RD: state_ff <= S_EMIT_LD;
            S_EMIT_LD: begin
               if (out_load) begin
                  out_bin_ff   <= bin_ff;
                  out_tally_ff <= tally_in;
                  out_lo_ff    <= min_ff ^ SIGN_BIT;
                  out_hi_ff    <= max_ff ^ SIGN_BIT;
                  out_empty_ff <= 1'b0;
                  if (NB_W'(bin_ff) + 7'd1 == nb_eff) begin
                     out_last_ff  <= 1'b1;
                     held_ff      <= '0;
                     min_ff       <= '1;
                     max_ff       <= '0;
                     ovf_ff       <= 1'b0;
                     cnt_valid_ff <= '0;
                     state_ff     <= S_LOAD;
                  end else begin
                     out_last_ff <= 1'b0;
                     bin_ff      <= bin_ff + 6'd1;
                     state_ff    <= S_EMIT_RD;
                  end
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, out_nulls_ff, out_distinct_ff, out_grand_ff, out_hi_ff,
                        out_lo_ff, out_tally_ff, out_bin_ff};
   assign rsp_tuser  = {out_ovf_ff, out_empty_ff};
   assign rsp_tlast  = out_last_ff;

   `EWH_NEVER(a_held_bound, clock, reset, held_ff > HW'(MAX_SAMPLES), "sample count beyond capacity")
   `EWH_ASSERT(a_div_done, clock, reset, div_res.done |-> state_ff == S_DIV_WAIT, "stray divider done")
   `EWH_ASSERT(a_out_free, clock, reset, out_load |-> (!rsp_valid_ff || rsp_tready), "result overwritten")
   `EWH_ASSERT(a_min_max, clock, reset, held_ff != '0 |-> min_ff <= max_ff, "min above max")
endmodule

// ----- sim/equi_width_histogram_builder_core_tb.sv -----
// testbench for the equi-width histogram builder: random and directed sample sets, self-checking
`timescale 1ns / 1ps
module equi_width_histogram_builder_core_tb;
   import ewh_pkg::*;

   localparam int STORE_DEPTH = 1024;
   localparam int WATCHDOG_LIMIT = 200000;

   typedef struct {
      logic [31:0] value;
      logic        present;
      logic        final_flag;
   } sample_item_type;

   typedef struct {
      logic [5:0]  bin_number;
      logic [10:0] bin_tally;
      logic [31:0] range_low;
      logic [31:0] range_high;
      logic [16:0] grand_total;
      logic [15:0] distinct_out;
      logic [15:0] nulls_out;
      logic        empty_set;
      logic        overflowed;
      logic        last_result;
   } bin_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   sample_item_type pending_samples[$];
   bin_result_type  expected_bins[$];
   int error_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   // histogram state mirror, samples kept offset-binary
   logic [31:0] held_store[STORE_DEPTH];
   int          held_count = 0;
   logic [31:0] low_biased = 32'hFFFF_FFFF;
   logic [31:0] high_biased = 32'h0;
   logic        dropped_any = 1'b0;
   logic [6:0]  cfg_bins = BINS_RESET;
   logic [15:0] cfg_nulls = '0;
   logic [15:0] cfg_distinct = '0;

   equi_width_histogram_builder_core u_top (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h", field, got, want);
      error_count++;
   endtask

   function automatic void bin_sample_set(sample_item_type it);
      logic [31:0] biased;
      int nb;
      int tally[64];
      longint unsigned span, off, b;
      bin_result_type r;
      biased = it.value ^ SIGN_BIT;
      if (it.present) begin
         if (held_count < STORE_DEPTH) begin
            held_store[held_count] = biased;
            held_count++;
            if (biased < low_biased) low_biased = biased;
            if (biased > high_biased) high_biased = biased;
         end else begin
            dropped_any = 1'b1;
         end
      end
      if (!it.final_flag) return;
      r.grand_total = 17'(held_count + cfg_nulls);
      r.distinct_out = cfg_distinct;
      r.nulls_out = cfg_nulls;
      r.overflowed = dropped_any;
      if (held_count == 0) begin
         r.bin_number = '0;
         r.bin_tally = '0;
         r.range_low = '0;
         r.range_high = '0;
         r.empty_set = 1'b1;
         r.last_result = 1'b1;
         expected_bins = {expected_bins, r};
      end else begin
         nb = (cfg_bins == 0) ? 1 : (cfg_bins > 64) ? 64 : cfg_bins;
         foreach (tally[i]) tally[i] = 0;
         if (high_biased > low_biased) begin
            span = high_biased - low_biased;
            for (int i = 0; i < held_count; i++) begin
               off = held_store[i] - low_biased;
               b = (off * nb) / span;
               if (b >= nb) b = nb - 1;
               tally[b]++;
            end
         end else begin
            tally[0] = held_count;
         end
         for (int i = 0; i < nb; i++) begin
            r.bin_number = 6'(i);
            r.bin_tally = 11'(tally[i]);
            r.range_low = low_biased ^ SIGN_BIT;
            r.range_high = high_biased ^ SIGN_BIT;
            r.empty_set = 1'b0;
            r.last_result = (i == nb - 1);
            expected_bins = {expected_bins, r};
         end
      end
      held_count = 0;
      low_biased = 32'hFFFF_FFFF;
      high_biased = 32'h0;
      dropped_any = 1'b0;
   endfunction

   // driver
   always @(posedge clock) begin
      sample_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            nxt.value = req_tdata;
            nxt.present = req_tuser;
            nxt.final_flag = req_tlast;
            bin_sample_set(nxt);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               nxt = pending_samples.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= nxt.value;
               req_tuser <= nxt.present;
               req_tlast <= nxt.final_flag;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      bin_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bins.size() == 0) begin
               $display("unexpected result transaction: %h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_bins.pop_front();
               if (rsp_tdata[5:0] !== want.bin_number)
                  report_mismatch("bin_number", rsp_tdata[5:0], want.bin_number);
               if (rsp_tdata[16:6] !== want.bin_tally)
                  report_mismatch("bin_tally", rsp_tdata[16:6], want.bin_tally);
               if (rsp_tdata[48:17] !== want.range_low)
                  report_mismatch("range_low", rsp_tdata[48:17], want.range_low);
               if (rsp_tdata[80:49] !== want.range_high)
                  report_mismatch("range_high", rsp_tdata[80:49], want.range_high);
               if (rsp_tdata[97:81] !== want.grand_total)
                  report_mismatch("grand_total", rsp_tdata[97:81], want.grand_total);
               if (rsp_tdata[113:98] !== want.distinct_out)
                  report_mismatch("distinct_out", rsp_tdata[113:98], want.distinct_out);
               if (rsp_tdata[129:114] !== want.nulls_out)
                  report_mismatch("nulls_out", rsp_tdata[129:114], want.nulls_out);
               if (rsp_tuser[0] !== want.empty_set)
                  report_mismatch("empty_set", rsp_tuser[0], want.empty_set);
               if (rsp_tuser[1] !== want.overflowed)
                  report_mismatch("overflowed", rsp_tuser[1], want.overflowed);
               if (rsp_tlast !== want.last_result)
                  report_mismatch("last_result", rsp_tlast, want.last_result);
            end
         end
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_sample(logic [31:0] v, logic present, logic fin);
      sample_item_type it;
      it.value = v;
      it.present = present;
      it.final_flag = fin;
      pending_samples = {pending_samples, it};
   endtask

   task automatic push_set(int n, logic [31:0] val_list[$]);
      for (int i = 0; i < n; i++) push_sample(val_list[i], 1'b1, i == n - 1);
   endtask

   task automatic push_random_sets(int item_budget);
      int n, spread, used;
      logic [31:0] base, v;
      used = 0;
      while (used < item_budget) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(40, 15) : $urandom_range(8, 1);
         spread = $urandom_range(3);
         base = $urandom;
         for (int i = 0; i < n; i++) begin
            case (spread)
               0: v = $urandom;
               1: v = base + $urandom_range(20);
               2: v = base;
               default: v = base ^ (32'(1) << $urandom_range(31));
            endcase
            // occasional bare marker inside the set
            push_sample(v, $urandom_range(15) != 0, i == n - 1);
         end
         used += n;
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      case (idx)
         CSR_BIN_COUNT: cfg_bins = val[6:0];
         CSR_NULLS: cfg_nulls = val;
         default: cfg_distinct = val;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_all();
      while (pending_samples.size() > 0 || req_tvalid || expected_bins.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      logic [31:0] vals[$];
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed sets at reset configuration
      push_sample('0, 1'b0, 1'b1);
      push_sample(32'h7FFF_FFFF, 1'b1, 1'b1);
      vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h4000_0000};
      push_set(5, vals);
      push_sample(32'h1234, 1'b1, 1'b0);
      push_sample(32'h0, 1'b0, 1'b0);
      push_sample(32'h1234, 1'b1, 1'b0);
      push_sample(32'h0, 1'b0, 1'b1);
      drain_all();

      write_csr(CSR_BIN_COUNT, 16'd0);
      write_csr(CSR_NULLS, 16'hFFFF);
      write_csr(CSR_DISTINCT, 16'hFFFF);
      vals = '{32'd5, 32'd9, 32'd7};
      push_set(3, vals);
      drain_all();

      write_csr(CSR_BIN_COUNT, 16'd127);
      write_csr(CSR_NULLS, 16'd0);
      write_csr(CSR_DISTINCT, 16'd1);
      vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1};
      push_set(4, vals);
      drain_all();

      // long receiver hold while results back up and the next set waits at the input
      write_csr(CSR_BIN_COUNT, 16'd64);
      hold_request = 400;
      push_set(1, '{32'd3});
      push_set(2, '{32'd3, 32'd4});
      drain_all();

      // random phases across idle patterns
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            1: begin sender_idle_pct = 46; receiver_stall_pct = 0; end
            2: begin sender_idle_pct = 0; receiver_stall_pct = 46; end
            default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
         endcase
         write_csr(CSR_BIN_COUNT, (ph == 0) ? 16'd1 : 16'($urandom_range(64, 1)));
         write_csr(CSR_NULLS, 16'($urandom));
         write_csr(CSR_DISTINCT, 16'($urandom));
         if (ph == 2) hold_request = 300;
         push_random_sets(75);
         drain_all();
      end

      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
